// File: design/lps_pkg.sv
// Shared types, register indexes, color codes and breathing tables for the LED sequencer.
`timescale 1ns / 1ps
package lps_pkg;

  // Update item: mode plus the current millisecond tick
  typedef struct packed {
    logic        mode;
    logic [31:0] now_ms;
  } lps_in_t;

  // Result item: PWM compare values and phase status
  typedef struct packed {
    logic        drive_valid;
    logic [12:0] red_drive;
    logic [12:0] green_drive;
    logic [12:0] blue_drive;
    logic [3:0]  phase_index;
    logic        pattern_ended;
  } lps_out_t;

  // Configuration register indexes
  localparam logic [1:0] REG_PHASE_COUNT    = 2'd0;
  localparam logic [1:0] REG_PHASE_COLORS   = 2'd1;
  localparam logic [1:0] REG_DURATIONS_LOW  = 2'd2;
  localparam logic [1:0] REG_DURATIONS_HIGH = 2'd3;

  localparam logic [3:0] PHASE_COUNT_RESET = 4'd2;

  // Item modes
  localparam logic MODE_UPDATE  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Color codes
  localparam logic [3:0] COLOR_BLACK        = 4'd0;
  localparam logic [3:0] COLOR_ORANGE       = 4'd1;
  localparam logic [3:0] COLOR_PINK         = 4'd2;
  localparam logic [3:0] COLOR_YELLOW       = 4'd3;
  localparam logic [3:0] COLOR_BLUE         = 4'd4;
  localparam logic [3:0] COLOR_RED          = 4'd5;
  localparam logic [3:0] COLOR_GREEN        = 4'd8;
  localparam logic [3:0] COLOR_TEAL         = 4'd9;
  localparam logic [3:0] COLOR_OFF          = 4'd10;
  localparam logic [3:0] COLOR_CYAN         = 4'd11;
  localparam logic [3:0] COLOR_BREATH_CYAN  = 4'd12;
  localparam logic [3:0] COLOR_BREATH_MAG   = 4'd13;
  localparam logic [3:0] COLOR_BREATH_AMBER = 4'd14;

  // Breathing table length
  localparam int TABLE_LEN = 100;

  // trunc(128 + 127*sin(a))
  localparam logic [7:0] TAB_S [TABLE_LEN] = '{
    8'd128, 8'd135, 8'd143, 8'd151, 8'd159, 8'd167, 8'd174, 8'd182, 8'd189, 8'd196,
    8'd202, 8'd208, 8'd214, 8'd220, 8'd225, 8'd230, 8'd235, 8'd239, 8'd242, 8'd246,
    8'd248, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd254, 8'd253, 8'd252, 8'd251,
    8'd248, 8'd246, 8'd242, 8'd239, 8'd235, 8'd230, 8'd225, 8'd220, 8'd214, 8'd208,
    8'd202, 8'd196, 8'd189, 8'd182, 8'd174, 8'd167, 8'd159, 8'd151, 8'd143, 8'd135,
    8'd128, 8'd120, 8'd112, 8'd104, 8'd96,  8'd88,  8'd81,  8'd73,  8'd66,  8'd59,
    8'd53,  8'd47,  8'd41,  8'd35,  8'd30,  8'd25,  8'd20,  8'd16,  8'd13,  8'd9,
    8'd7,   8'd4,   8'd3,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd3,   8'd4,
    8'd7,   8'd9,   8'd13,  8'd16,  8'd20,  8'd25,  8'd30,  8'd35,  8'd41,  8'd47,
    8'd53,  8'd59,  8'd66,  8'd73,  8'd81,  8'd88,  8'd96,  8'd104, 8'd112, 8'd120
  };

  // trunc(30 + 30*sin(a))
  localparam logic [7:0] TAB_H [TABLE_LEN] = '{
    8'd30, 8'd31, 8'd33, 8'd35, 8'd37, 8'd39, 8'd41, 8'd42, 8'd44, 8'd46,
    8'd47, 8'd49, 8'd50, 8'd51, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd57,
    8'd58, 8'd59, 8'd59, 8'd59, 8'd59, 8'd59, 8'd59, 8'd59, 8'd59, 8'd59,
    8'd58, 8'd57, 8'd57, 8'd56, 8'd55, 8'd54, 8'd53, 8'd51, 8'd50, 8'd49,
    8'd47, 8'd46, 8'd44, 8'd42, 8'd41, 8'd39, 8'd37, 8'd35, 8'd33, 8'd31,
    8'd30, 8'd28, 8'd26, 8'd24, 8'd22, 8'd20, 8'd18, 8'd17, 8'd15, 8'd13,
    8'd12, 8'd10, 8'd9,  8'd8,  8'd6,  8'd5,  8'd4,  8'd3,  8'd2,  8'd2,
    8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd1,  8'd2,  8'd2,  8'd3,  8'd4,  8'd5,  8'd6,  8'd8,  8'd9,  8'd10,
    8'd12, 8'd13, 8'd15, 8'd17, 8'd18, 8'd20, 8'd22, 8'd24, 8'd26, 8'd28
  };

  // trunc(40 + 40*sin(a))
  localparam logic [7:0] TAB_F [TABLE_LEN] = '{
    8'd40, 8'd42, 8'd45, 8'd47, 8'd49, 8'd52, 8'd54, 8'd57, 8'd59, 8'd61,
    8'd63, 8'd65, 8'd67, 8'd69, 8'd70, 8'd72, 8'd73, 8'd75, 8'd76, 8'd77,
    8'd78, 8'd78, 8'd79, 8'd79, 8'd79, 8'd79, 8'd79, 8'd79, 8'd79, 8'd78,
    8'd78, 8'd77, 8'd76, 8'd75, 8'd73, 8'd72, 8'd70, 8'd69, 8'd67, 8'd65,
    8'd63, 8'd61, 8'd59, 8'd57, 8'd54, 8'd52, 8'd49, 8'd47, 8'd45, 8'd42,
    8'd40, 8'd37, 8'd34, 8'd32, 8'd30, 8'd27, 8'd25, 8'd22, 8'd20, 8'd18,
    8'd16, 8'd14, 8'd12, 8'd10, 8'd9,  8'd7,  8'd6,  8'd4,  8'd3,  8'd2,
    8'd1,  8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd1,
    8'd1,  8'd2,  8'd3,  8'd4,  8'd6,  8'd7,  8'd9,  8'd10, 8'd12, 8'd14,
    8'd16, 8'd18, 8'd20, 8'd22, 8'd25, 8'd27, 8'd30, 8'd32, 8'd34, 8'd37
  };

endpackage

// File: design/led_pattern_sequencer.sv
// LED pattern sequencer top level: input register, phase logic, result register.
`timescale 1ns / 1ps
// Path: input register, then result register. Throughput: one item per cycle while
//   the result side is not stalled; the phase state updates as the item moves into
//   the result register, so the next item sees it with no bubble.
// The input side stalls only while a full input stage waits on a stalled result.
// Reset (rst, synchronous): pipeline empty, phase state zero, phase_count = 2,
//   colors and durations zero.
module led_pattern_sequencer
  import lps_pkg::*;
#(
  parameter int MAX_PHASES   = 8,
  parameter int BREATH_STEPS = 100
) (
  input  logic        clk,
  input  logic        rst,
  // update items
  input  logic        item_valid,
  output logic        item_stall,
  input  lps_in_t     item,
  // result items
  output logic        result_valid,
  input  logic        result_stall,
  output lps_out_t    result,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int BW = $clog2(BREATH_STEPS);

  // configuration registers
  logic [3:0]  phase_count;
  logic [31:0] phase_colors;
  logic [63:0] durations_low;
  logic [63:0] durations_high;

  // input stage
  logic        held_valid;
  lps_in_t     held;

  // sequencer state
  logic [3:0]    phase, phase_next;
  logic [31:0]   phase_start, phase_start_next;
  logic [7:0]    pass_count, pass_count_next;
  logic [BW-1:0] breath_step, breath_step_next;
  logic          ended_flag, ended_flag_next;

  logic          advance;
  logic          drive;
  logic          wrap;
  logic [3:0]    len;
  logic [3:0]    cur_phase;
  logic [63:0]   dur_word;
  logic [15:0]   dur;
  logic [31:0]   elapsed;
  logic [7:0]    k_wide;
  logic [6:0]    k;
  logic [12:0]   red, green, blue;

  // Input stage moves on when the result register is empty or being taken.
  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count    <= PHASE_COUNT_RESET;
      phase_colors   <= '0;
      durations_low  <= '0;
      durations_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_COUNT:    phase_count    <= cfg_data[3:0];
        REG_PHASE_COLORS:   phase_colors   <= cfg_data[31:0];
        REG_DURATIONS_LOW:  durations_low  <= cfg_data;
        REG_DURATIONS_HIGH: durations_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  // Pattern length clamps to the phase table size.
  assign len = (phase_count > 4'(MAX_PHASES)) ? 4'(MAX_PHASES) : phase_count;

  // Past the end of the pattern: fold back to phase 0 before anything else.
  assign wrap      = (phase >= len);
  assign cur_phase = wrap ? 4'd0 : phase;

  assign dur_word = cur_phase[2] ? durations_high : durations_low;
  assign dur      = dur_word[{cur_phase[1:0], 4'b0} +: 16];
  assign elapsed  = held.now_ms - phase_start;

  always_comb begin
    phase_next       = phase;
    phase_start_next = phase_start;
    pass_count_next  = pass_count;
    breath_step_next = breath_step;
    ended_flag_next  = ended_flag;
    drive            = 1'b0;
    if (held.mode == MODE_RESTART) begin
      phase_next      = 4'd0;
      pass_count_next = 8'd0;
    end else begin
      if (wrap) begin
        ended_flag_next = 1'b1;
        pass_count_next = (pass_count == 8'd199) ? 8'd0 : pass_count + 8'd1;
      end
      if (cur_phase == 4'd0) begin
        // first phase drives nothing: it stamps the start time and moves on to phase 1
        phase_start_next = held.now_ms;
        phase_next       = 4'd1;
        ended_flag_next  = 1'b0;
      end else if (elapsed >= {16'b0, dur}) begin
        phase_start_next = held.now_ms;
        phase_next       = cur_phase + 4'd1;
      end else begin
        breath_step_next = (breath_step == BW'(BREATH_STEPS - 1)) ? '0
                                                                  : breath_step + 1'b1;
        drive = 1'b1;
      end
    end
  end

  // Table index is the breathing step modulo the table length.
  always_comb begin
    k_wide = 8'(breath_step_next);
    if (k_wide >= 8'(2 * TABLE_LEN)) begin
      k_wide = k_wide - 8'(2 * TABLE_LEN);
    end else if (k_wide >= 8'(TABLE_LEN)) begin
      k_wide = k_wide - 8'(TABLE_LEN);
    end
  end
  assign k = k_wide[6:0];

  lps_color u_color (
    .code         (phase_colors[{cur_phase[2:0], 2'b0} +: 4]),
    .breath_index (k),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      phase_start <= '0;
      pass_count  <= '0;
      breath_step <= '0;
      ended_flag  <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      phase_start <= phase_start_next;
      pass_count  <= pass_count_next;
      breath_step <= breath_step_next;
      ended_flag  <= ended_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.drive_valid   <= drive;
      result.red_drive     <= drive ? red : '0;
      result.green_drive   <= drive ? green : '0;
      result.blue_drive    <= drive ? blue : '0;
      result.phase_index   <= phase_next;
      result.pattern_ended <= ended_flag_next;
    end
  end

endmodule

// File: design/lps_color.sv
// Color decoder: phase color code and breathing index to PWM compare values.
`timescale 1ns / 1ps
module lps_color
  import lps_pkg::*;
(
  input  logic [3:0]  code,
  input  logic [6:0]  breath_index,
  output logic [12:0] red,
  output logic [12:0] green,
  output logic [12:0] blue
);

  logic [7:0] s;
  logic [7:0] h;
  logic [7:0] f;
  logic [7:0] r8;
  logic [7:0] g8;
  logic [7:0] b8;

  assign s = TAB_S[breath_index];
  assign h = TAB_H[breath_index];
  assign f = TAB_F[breath_index];

  always_comb begin
    unique case (code) inside
      COLOR_BLACK, COLOR_OFF: begin r8 = 8'd0;   g8 = 8'd0;   b8 = 8'd0;   end
      COLOR_ORANGE:       begin r8 = 8'd255; g8 = 8'd80;  b8 = 8'd0;   end
      COLOR_PINK:         begin r8 = 8'd255; g8 = 8'd60;  b8 = 8'd255; end
      COLOR_YELLOW:       begin r8 = 8'd255; g8 = 8'd200; b8 = 8'd0;   end
      COLOR_BLUE:         begin r8 = 8'd0;   g8 = 8'd0;   b8 = 8'd255; end
      COLOR_RED:          begin r8 = 8'd255; g8 = 8'd0;   b8 = 8'd0;   end
      COLOR_GREEN:        begin r8 = 8'd0;   g8 = 8'd255; b8 = 8'd0;   end
      COLOR_TEAL:         begin r8 = 8'd24;  g8 = 8'd105; b8 = 8'd100; end
      COLOR_CYAN:         begin r8 = 8'd0;   g8 = 8'd255; b8 = 8'd255; end
      COLOR_BREATH_CYAN:  begin r8 = 8'd0;   g8 = s;      b8 = s;      end
      COLOR_BREATH_MAG:   begin r8 = s;      g8 = h;      b8 = s;      end
      COLOR_BREATH_AMBER: begin r8 = s;      g8 = f;      b8 = 8'd0;   end
      default:            begin r8 = 8'd255; g8 = 8'd255; b8 = 8'd255; end
    endcase
  end

  // x*31 = x*32 - x
  assign red   = {r8, 5'b0} - {5'b0, r8};
  assign green = {g8, 5'b0} - {5'b0, g8};
  assign blue  = {b8, 5'b0} - {5'b0, b8};

endmodule

// File: sim/lps_checker.sv
// Checker for the LED pattern sequencer: tracks settings, predicts each result, compares.
`timescale 1ns / 1ps
module lps_checker
  import lps_pkg::*;
#(
  parameter int MAX_PHASES   = 8,
  parameter int BREATH_STEPS = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  lps_in_t     item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  lps_out_t    result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);

  localparam int DRIVE_SCALE = 31;
  localparam int PASS_WRAP   = 200;
  localparam int MAX_REPORTS = 24;

  // settings copy
  logic [3:0]  count_reg;
  logic [31:0] colors_reg;
  logic [63:0] dur_lo_reg;
  logic [63:0] dur_hi_reg;

  // sequencer state copy
  logic [3:0]  seq_phase;
  logic [31:0] seq_start;
  logic [7:0]  seq_passes;
  logic [7:0]  seq_breath;
  logic        seq_ended;

  lps_out_t pending_drives[$];
  int       fails;

  function automatic logic [15:0] duration_of(logic [2:0] p);
    logic [63:0] word;
    word = p[2] ? dur_hi_reg : dur_lo_reg;
    return word[16*p[1:0] +: 16];
  endfunction

  function automatic void rgb_for(input logic [3:0] code, input int k,
                                  output logic [7:0] r, output logic [7:0] g,
                                  output logic [7:0] b);
    logic [7:0] s, h, f;
    s = TAB_S[k];
    h = TAB_H[k];
    f = TAB_F[k];
    case (code)
      COLOR_BLACK, COLOR_OFF: begin r = 8'd0;   g = 8'd0;   b = 8'd0;   end
      COLOR_ORANGE:           begin r = 8'd255; g = 8'd80;  b = 8'd0;   end
      COLOR_PINK:             begin r = 8'd255; g = 8'd60;  b = 8'd255; end
      COLOR_YELLOW:           begin r = 8'd255; g = 8'd200; b = 8'd0;   end
      COLOR_BLUE:             begin r = 8'd0;   g = 8'd0;   b = 8'd255; end
      COLOR_RED:              begin r = 8'd255; g = 8'd0;   b = 8'd0;   end
      COLOR_GREEN:            begin r = 8'd0;   g = 8'd255; b = 8'd0;   end
      COLOR_TEAL:             begin r = 8'd24;  g = 8'd105; b = 8'd100; end
      COLOR_CYAN:             begin r = 8'd0;   g = 8'd255; b = 8'd255; end
      COLOR_BREATH_CYAN:      begin r = 8'd0;   g = s;      b = s;      end
      COLOR_BREATH_MAG:       begin r = s;      g = h;      b = s;      end
      COLOR_BREATH_AMBER:     begin r = s;      g = f;      b = 8'd0;   end
      default:                begin r = 8'd255; g = 8'd255; b = 8'd255; end
    endcase
  endfunction

  // Advance the state copy by one item and return the drive it produces.
  function automatic lps_out_t next_drive(lps_in_t it);
    lps_out_t   res;
    int         len;
    logic [7:0] r, g, b;
    res = '0;
    len = (count_reg > MAX_PHASES) ? MAX_PHASES : int'(count_reg);
    if (it.mode == MODE_RESTART) begin
      seq_phase  = 4'd0;
      seq_passes = 8'd0;
    end else begin
      if (seq_phase >= len) begin
        seq_phase  = 4'd0;
        seq_ended  = 1'b1;
        seq_passes = (seq_passes + 1 >= PASS_WRAP) ? 8'd0 : seq_passes + 8'd1;
      end
      if (seq_phase == 4'd0) begin
        seq_start = it.now_ms;
        seq_phase = 4'd1;
        seq_ended = 1'b0;
      end else if (32'(it.now_ms - seq_start) >= duration_of(seq_phase[2:0])) begin
        seq_start = it.now_ms;
        seq_phase = seq_phase + 4'd1;
      end else begin
        seq_breath = (seq_breath + 1 >= BREATH_STEPS) ? 8'd0 : seq_breath + 8'd1;
        rgb_for(colors_reg[4*seq_phase[2:0] +: 4], seq_breath % TABLE_LEN, r, g, b);
        res.drive_valid = 1'b1;
        res.red_drive   = 13'(r * DRIVE_SCALE);
        res.green_drive = 13'(g * DRIVE_SCALE);
        res.blue_drive  = 13'(b * DRIVE_SCALE);
      end
    end
    res.phase_index   = seq_phase;
    res.pattern_ended = seq_ended;
    return res;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    lps_out_t want;
    if (rst) begin
      count_reg  = PHASE_COUNT_RESET;
      colors_reg = '0;
      dur_lo_reg = '0;
      dur_hi_reg = '0;
      seq_phase  = '0;
      seq_start  = '0;
      seq_passes = '0;
      seq_breath = '0;
      seq_ended  = 1'b0;
      pending_drives.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_COUNT:    count_reg  = cfg_data[3:0];
          REG_PHASE_COLORS:   colors_reg = cfg_data[31:0];
          REG_DURATIONS_LOW:  dur_lo_reg = cfg_data;
          REG_DURATIONS_HIGH: dur_hi_reg = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (pending_drives.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none actual %h", $time, result);
        end else begin
          want = pending_drives.pop_front();
          check_field("drive_valid", want.drive_valid, result.drive_valid);
          check_field("red_drive", want.red_drive, result.red_drive);
          check_field("green_drive", want.green_drive, result.green_drive);
          check_field("blue_drive", want.blue_drive, result.blue_drive);
          check_field("phase_index", want.phase_index, result.phase_index);
          check_field("pattern_ended", want.pattern_ended, result.pattern_ended);
        end
      end
      if (item_valid && !item_stall)
        pending_drives.push_back(next_drive(item));
    end
    outstanding <= pending_drives.size();
    fail_count  <= fails;
  end

endmodule

// File: sim/led_pattern_sequencer_test.sv
// Testbench top for the LED pattern sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module led_pattern_sequencer_test;
  import lps_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int ITEM_TARGET  = 450;
  localparam int MAX_GAP      = 18;
  localparam int DRAIN_CYCLES = 8;      // margin after the last outstanding result
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  lps_in_t     item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  lps_out_t    result;
  logic        cfg_we       = 1'b0;
  logic [1:0]  cfg_index    = REG_PHASE_COUNT;
  logic [63:0] cfg_data     = '0;

  int          fail_count;
  int          outstanding;
  int          cycle_count  = 0;
  int          stall_left   = 0;
  int          sent         = 0;
  logic        steady       = 1'b0; // when set, neither side idles
  logic [31:0] clock_ms     = '0;   // running millisecond tick for well-formed sequences

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  led_pattern_sequencer u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  lps_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // Receiver: after each accepted result, hold stall for a random number of cycles.
  always @(posedge clk) begin
    int hold;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (result_valid && !result_stall) begin
      hold = steady ? 0 : $urandom_range(MAX_GAP);
      stall_left   <= hold;
      result_stall <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= (stall_left != 1);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one item after a random gap, return on the edge that accepts it.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic send_item(logic mode, logic [31:0] now);
    int gap;
    gap = steady ? 0 : $urandom_range(MAX_GAP);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    item.mode   <= mode;
    item.now_ms <= now;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; unused upper bits carry noise.
  task automatic configure(logic [3:0] count, logic [31:0] colors,
                           logic [63:0] dur_lo, logic [63:0] dur_hi);
    logic [63:0] word;
    word       = {$urandom, $urandom};
    word[3:0]  = count;
    cfg_we    <= 1'b1;
    cfg_index <= REG_PHASE_COUNT;
    cfg_data  <= word;
    @(posedge clk);
    cfg_index <= REG_PHASE_COLORS;
    cfg_data  <= {$urandom, colors};
    @(posedge clk);
    cfg_index <= REG_DURATIONS_LOW;
    cfg_data  <= dur_lo;
    @(posedge clk);
    cfg_index <= REG_DURATIONS_HIGH;
    cfg_data  <= dur_hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly short phases so patterns actually run; some zero, full-scale or wild.
  function automatic logic [15:0] pick_duration(bit tight);
    int pick;
    pick = $urandom_range(9);
    if (tight) return 16'($urandom_range(1, 8));
    case (pick)
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(16'hFFFF));
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [3:0] pick_count();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return 4'd0;
      1:       return 4'd1;
      2:       return 4'($urandom_range(9, 15)); // above the phase limit
      default: return 4'($urandom_range(2, 8));
    endcase
  endfunction

  task automatic random_config(logic [3:0] count, logic [31:0] colors, bit tight);
    logic [63:0] lo, hi;
    for (int i = 0; i < 4; i++) begin
      lo[16*i +: 16] = pick_duration(tight);
      hi[16*i +: 16] = pick_duration(tight);
    end
    configure(count, colors, lo, hi);
  endtask

  // Mostly a tick that creeps forward; some big jumps, wild ticks and restarts.
  task automatic run_segment(int n_items);
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_item(MODE_RESTART, $urandom);
      end else begin
        if (pick < 9)
          clock_ms = $urandom;
        else if (pick < 15)
          clock_ms = clock_ms + $urandom_range(70000);
        else
          clock_ms = clock_ms + $urandom_range(6);
        send_item(MODE_UPDATE, clock_ms);
      end
    end
  endtask

  initial begin
    int seg;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: two phases, zero durations, so every update moves on.
    send_item(MODE_UPDATE, 32'h0000_0000);
    send_item(MODE_UPDATE, 32'hFFFF_FFFF);
    send_item(MODE_UPDATE, 32'd5);
    send_item(MODE_RESTART, 32'hFFFF_FFFF);
    send_item(MODE_UPDATE, 32'h8000_0000);
    drain();

    // Count above the limit, breathing colors, full-scale and zero durations.
    // The tick wraps through zero while phase 1 is lit, then the elapsed time
    // lands exactly on the duration, then one below it.
    configure(4'd15, 32'h0000_0DC0, 64'h0000_FFFF_FFFF_0000, 64'h0);
    send_item(MODE_RESTART, 32'h0);
    send_item(MODE_UPDATE, 32'hFFFF_FFF0);
    send_item(MODE_UPDATE, 32'h0000_000F);
    send_item(MODE_UPDATE, 32'h0000_FFEF);
    send_item(MODE_UPDATE, 32'h0001_FFED);
    for (int i = 0; i < 6; i++)
      send_item(MODE_UPDATE, 32'h0001_FFEE + i);
    drain();

    // Zero and one phase: every update wraps the pattern.
    configure(4'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_UPDATE, 32'd100);
    send_item(MODE_UPDATE, 32'd101);
    drain();
    configure(4'd1, 32'h1234_5678, 64'h0, 64'h0);
    send_item(MODE_UPDATE, 32'd200);
    send_item(MODE_UPDATE, 32'd200);
    drain();

    // Random part: the first two segments place every color code in a full eight-phase
    // pattern, where phase 0 never lights; later ones use random settings.
    seg = 0;
    sent = 0;
    while (sent < ITEM_TARGET) begin
      steady <= ($urandom_range(3) == 0);
      case (seg)
        0:       random_config(4'd8, 32'h7654_3210, 1'b1);
        1:       random_config(4'd8, 32'hFEDC_BA98, 1'b1);
        default: random_config(pick_count(), $urandom, 1'b0);
      endcase
      run_segment($urandom_range(25, 60));
      drain();
      seg++;
    end

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
